// ===== rtl/dam_pkg.sv =====
// Shared types and constants for the decimal accumulator machine step unit.
// Depends on nothing; imported by decimal_accumulator_machine_step_unit.
`default_nettype none

package dam_pkg;

  localparam int WORD_W = 10;

  localparam logic [WORD_W-1:0] WORD_MAX  = 10'd999;
  localparam logic [11:0]       WORD_MOD  = 12'd1000;
  localparam logic [WORD_W-1:0] INSTR_IN  = 10'd901;
  localparam logic [WORD_W-1:0] INSTR_OUT = 10'd902;
  localparam logic [WORD_W-1:0] DEC_BASE  = 10'd100;

  // floor(x / 100) equals (x * 41) >> 12 for every x up to 999.
  localparam logic [15:0] DIV100_MUL   = 16'd41;
  localparam int          DIV100_SHIFT = 12;

  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_STA = 4'd3;
  localparam logic [3:0] OP_LDA = 4'd5;
  localparam logic [3:0] OP_BRA = 4'd6;
  localparam logic [3:0] OP_BRZ = 4'd7;
  localparam logic [3:0] OP_BRP = 4'd8;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_FETCH  = 6'b000100,
    ST_DECODE = 6'b001000,
    ST_EXEC   = 6'b010000,
    ST_WRAP   = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/decimal_accumulator_machine_step_unit.sv =====
// Decimal accumulator machine: mailbox memory, sequencer and shared add/subtract unit.
// Depends on dam_pkg for word constants, opcodes and the state encoding.
//
// An item is taken when start is high and busy is low. A mailbox load goes through
// ST_LOAD before the done_o strobe; an executed instruction through ST_FETCH, ST_DECODE
// and ST_EXEC, and an ADD also ST_WRAP, because the mailbox memory's one read port is
// used once for the fetch and once for the operand, and the one 12-bit add/subtract unit
// does an ADD in two passes (sum, then the modulo-1000 correction). done_o is high for
// exactly one cycle and the result ports are valid only then; the receiver cannot stall
// it, and a new item may be started in that same cycle. acc_now_o, counter_now_o and
// negative_now_o show the machine state at all times. All MAILBOX_COUNT mailboxes
// (100 by default) read as zero after reset, with no clearing pass.
`default_nettype none

module decimal_accumulator_machine_step_unit #(
  parameter int MAILBOX_COUNT = 100,
  localparam int AW = $clog2(MAILBOX_COUNT)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [AW-1:0]              address_i,
  input  logic [dam_pkg::WORD_W-1:0] word_i,
  output logic                       done_o,
  output logic                       halted_o,
  output logic                       out_valid_o,
  output logic [dam_pkg::WORD_W-1:0] out_value_o,
  output logic [dam_pkg::WORD_W-1:0] acc_now_o,
  output logic [AW-1:0]              counter_now_o,
  output logic                       negative_now_o,
  output logic                       overflowed_o
);

  import dam_pkg::*;

  state_e state_q;

  logic [WORD_W-1:0]        mem_q [MAILBOX_COUNT];
  logic [MAILBOX_COUNT-1:0] valid_q;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [WORD_W-1:0]        rd_data_q;
  logic                     rd_valid_q;
  logic [WORD_W-1:0]        rd_word;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [WORD_W-1:0]        wr_data;

  logic [WORD_W-1:0] acc_q;
  logic [AW-1:0]     pc_q;
  logic              neg_q;
  logic [AW-1:0]     addr_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] instr_q;
  logic [3:0]        op_q;
  logic [AW-1:0]     opnd_q;
  logic [11:0]       tmp_q;

  logic              done_q;
  logic              res_halt_q;
  logic              res_outv_q;
  logic [WORD_W-1:0] res_outval_q;
  logic              res_ovf_q;

  logic              accept;
  logic [WORD_W-1:0] word_clamped;
  logic [AW-1:0]     pc_next;
  logic [15:0]       div_prod;
  logic [3:0]        op_d;
  logic [WORD_W-1:0] hundreds;
  logic [AW-1:0]     opnd_calc;
  logic              addr_in_range;

  logic [11:0] au_a;
  logic [11:0] au_b;
  logic        au_sub;
  logic [11:0] au_res;
  logic        au_neg;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign word_clamped  = (word_i > WORD_MAX) ? WORD_MAX : word_i;
  assign pc_next       = (pc_q == AW'(MAILBOX_COUNT - 1)) ? '0 : pc_q + 1'b1;
  assign addr_in_range = ({1'b0, addr_q} < (AW + 1)'(MAILBOX_COUNT));

  // Entries never written since reset read as zero.
  assign rd_word = rd_valid_q ? rd_data_q : '0;

  // Decode of the fetched word: hundreds digit by reciprocal multiply, then the
  // low two digits once the digit is registered.
  assign div_prod  = 16'(rd_word) * DIV100_MUL;
  assign op_d      = 4'(div_prod >> DIV100_SHIFT);
  assign hundreds  = 10'(10'(op_q) * DEC_BASE);
  assign opnd_calc = AW'(instr_q - hundreds);

  // Shared add/subtract unit; bit 11 is the sign of a difference.
  always_comb begin
    au_a   = {2'b00, acc_q};
    au_b   = {2'b00, rd_word};
    au_sub = (op_q == OP_SUB);
    if (state_q == ST_WRAP) begin
      au_a   = tmp_q;
      au_b   = WORD_MOD;
      au_sub = 1'b1;
    end
  end

  assign au_res = au_a + (au_sub ? ~au_b : au_b) + {11'b0, au_sub};
  assign au_neg = au_res[11];

  // Mailbox memory port control.
  assign rd_en   = (accept && action_i) || (state_q == ST_DECODE);
  assign rd_addr = (state_q == ST_DECODE) ? opnd_calc : pc_q;
  assign wr_en   = ((state_q == ST_LOAD) && addr_in_range) ||
                   ((state_q == ST_EXEC) && (op_q == OP_STA));
  assign wr_addr = (state_q == ST_LOAD) ? addr_q : opnd_q;
  assign wr_data = (state_q == ST_LOAD) ? word_q : acc_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      acc_q        <= '0;
      pc_q         <= '0;
      neg_q        <= 1'b0;
      addr_q       <= '0;
      word_q       <= '0;
      instr_q      <= '0;
      op_q         <= '0;
      opnd_q       <= '0;
      tmp_q        <= '0;
      done_q       <= 1'b0;
      res_halt_q   <= 1'b0;
      res_outv_q   <= 1'b0;
      res_outval_q <= '0;
      res_ovf_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            addr_q  <= address_i;
            word_q  <= word_clamped;
            state_q <= action_i ? ST_FETCH : ST_LOAD;
          end
        end
        ST_LOAD: begin
          res_halt_q   <= 1'b0;
          res_outv_q   <= 1'b0;
          res_outval_q <= '0;
          res_ovf_q    <= 1'b0;
          done_q       <= 1'b1;
          state_q      <= ST_IDLE;
        end
        ST_FETCH: begin
          instr_q <= rd_word;
          op_q    <= op_d;
          state_q <= ST_DECODE;
        end
        ST_DECODE: begin
          opnd_q  <= opnd_calc;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          res_halt_q   <= 1'b0;
          res_outv_q   <= 1'b0;
          res_outval_q <= '0;
          res_ovf_q    <= 1'b0;
          done_q       <= 1'b1;
          state_q      <= ST_IDLE;
          if (instr_q == INSTR_IN) begin
            acc_q <= word_q;
            pc_q  <= pc_next;
          end else if (instr_q == INSTR_OUT) begin
            res_outv_q   <= 1'b1;
            res_outval_q <= acc_q;
            pc_q         <= pc_next;
          end else begin
            case (op_q)
              OP_ADD: begin
                tmp_q   <= au_res;
                done_q  <= 1'b0;
                state_q <= ST_WRAP;
              end
              OP_SUB: begin
                if (au_neg) begin
                  neg_q <= 1'b1;
                end else begin
                  acc_q <= au_res[WORD_W-1:0];
                end
                pc_q <= pc_next;
              end
              OP_STA: begin
                pc_q <= pc_next;
              end
              OP_LDA: begin
                acc_q <= rd_word;
                pc_q  <= pc_next;
              end
              OP_BRA: begin
                pc_q <= opnd_q;
              end
              OP_BRZ: begin
                pc_q <= ((acc_q == '0) && !neg_q) ? opnd_q : pc_next;
              end
              OP_BRP: begin
                pc_q <= !neg_q ? opnd_q : pc_next;
              end
              default: begin
                res_halt_q <= 1'b1;
              end
            endcase
          end
        end
        ST_WRAP: begin
          // A sum of 1000 or more wraps; otherwise the first pass stands.
          if (!au_neg) begin
            acc_q     <= au_res[WORD_W-1:0];
            res_ovf_q <= 1'b1;
          end else begin
            acc_q <= tmp_q[WORD_W-1:0];
          end
          neg_q   <= 1'b0;
          pc_q    <= pc_next;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign halted_o       = res_halt_q;
  assign out_valid_o    = res_outv_q;
  assign out_value_o    = res_outval_q;
  assign acc_now_o      = acc_q;
  assign counter_now_o  = pc_q;
  assign negative_now_o = neg_q;
  assign overflowed_o   = res_ovf_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe raised while the sequencer is not idle");

  a_wrap_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRAP) |-> ($past(state_q) == ST_EXEC))
    else $error("wrap pass entered without an execute step");

  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pc_q} < (AW + 1)'(MAILBOX_COUNT)))
    else $error("program counter outside the mailbox range");

  a_ovf_clears_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_ovf_q) |-> (!neg_q && !res_halt_q && !res_outv_q))
    else $error("overflow reported with an inconsistent result");

  a_out_not_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_outv_q) |-> (!res_halt_q && (res_outval_q <= WORD_MAX)))
    else $error("output item marked halted or out of range");

endmodule

`default_nettype wire
